// ----- hw/rtl/ckt_pkg.sv -----
// Shared types and constants for the connection keepalive table.
// Used by the channel interfaces and every module of the block; no dependencies.
package ckt_pkg;

    // Table geometry
    localparam int SLOTS = 4;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Field widths
    localparam int OP_W      = 2;
    localparam int HANDLE_W  = 16;
    localparam int TIME_W    = 48;
    localparam int TIMEOUT_W = 24;
    localparam int KIND_W    = 4;
    localparam int SLOT_W    = 6;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT = '0;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 24'd60000;

    // Request codes
    typedef enum logic [OP_W-1:0] {
        OP_CONNECT    = 2'd0,
        OP_DISCONNECT = 2'd1,
        OP_ACTIVITY   = 2'd2,
        OP_TICK       = 2'd3
    } ckt_op_t;

    // Result codes
    typedef enum logic [KIND_W-1:0] {
        K_CONNECTED = 4'd0,
        K_DUPLICATE = 4'd1,
        K_FULL      = 4'd2,
        K_RELEASED  = 4'd3,
        K_NOT_FOUND = 4'd4,
        K_REFRESHED = 4'd5,
        K_PING      = 4'd6,
        K_TIMED_OUT = 4'd7,
        K_TICK_DONE = 4'd8
    } ckt_kind_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;         // capture the accepted item, restart the slot walk
        logic search_step;  // examine one slot for a handle match or a free slot
        logic resolve;      // update the table and emit the single result
        logic tick_step;    // examine one slot on a tick, act and emit if due
        logic tick_done;    // emit the closing tick result
    } ckt_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic op_tick;   // captured item is a tick
        logic idx_last;  // walk sits on the final slot
        logic out_free;  // output register can take a result this cycle
        logic tick_hit;  // current slot needs a ping or a timeout
    } ckt_sts_t;

endpackage

// ----- hw/rtl/ckt_in_if.sv -----
// Input channel: one request item (op, handle, time) with valid/ready.
// Depends on ckt_pkg for field widths.
interface ckt_in_if;
    logic                          valid;
    logic                          ready;
    logic [ckt_pkg::OP_W-1:0]      op;
    logic [ckt_pkg::HANDLE_W-1:0]  handle;
    logic [ckt_pkg::TIME_W-1:0]    now_ms;

    modport source (output valid, output op, output handle, output now_ms, input ready);
    modport sink   (input valid, input op, input handle, input now_ms, output ready);
endinterface

// ----- hw/rtl/ckt_out_if.sv -----
// Output channel: one result item (kind, handle, slot, last) with valid/ready.
// Depends on ckt_pkg for field widths.
interface ckt_out_if;
    logic                          valid;
    logic                          ready;
    logic [ckt_pkg::KIND_W-1:0]    kind;
    logic [ckt_pkg::HANDLE_W-1:0]  result_handle;
    logic [ckt_pkg::SLOT_W-1:0]    slot;
    logic                          last;

    modport source (output valid, output kind, output result_handle, output slot,
                    output last, input ready);
    modport sink   (input valid, input kind, input result_handle, input slot,
                    input last, output ready);
endinterface

// ----- hw/rtl/ckt_regs.sv -----
// APB-style configuration register file: holds the timeout register.
// Depends on ckt_pkg.
module ckt_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ckt_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ckt_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ckt_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output logic [ckt_pkg::TIMEOUT_W-1:0]     timeout_ms
);

    logic [ckt_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic [ckt_pkg::REG_IDX_W-1:0] reg_idx;
    logic                          wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ckt_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready
                     && (reg_idx == ckt_pkg::REG_TIMEOUT);

    // Write the timeout register in the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= ckt_pkg::TIMEOUT_RESET;
        end
        else if (wr_en)
        begin
            timeout_reg <= pwdata[ckt_pkg::TIMEOUT_W-1:0];
        end
    end

    // Read back; unmapped addresses read zero
    always_comb
    begin
        prdata = '0;
        if (reg_idx == ckt_pkg::REG_TIMEOUT)
        begin
            prdata = ckt_pkg::APB_DATA_W'(timeout_reg);
        end
    end

    assign timeout_ms = timeout_reg;

endmodule

// ----- hw/rtl/ckt_ctrl.sv -----
// Controller state machine: sequences the slot walk for each item.
// Depends on ckt_pkg for the command and status structs.
module ckt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ckt_pkg::ckt_sts_t sts,
    output ckt_pkg::ckt_cmd_t cmd
);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_SEARCH  = 5'b00010,
        S_RESOLVE = 5'b00100,
        S_TICK    = 5'b01000,
        S_TDONE   = 5'b10000
    } ckt_state_t;

    ckt_state_t state_reg;
    ckt_state_t state_next;

    // Advance the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decode next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                // the captured op is visible from here on
                if (sts.op_tick)
                begin
                    state_next = S_TICK;
                end
                else
                begin
                    cmd.search_step = 1'b1;
                    if (sts.idx_last)
                    begin
                        state_next = S_RESOLVE;
                    end
                end
            end
            S_RESOLVE:
            begin
                if (sts.out_free)
                begin
                    cmd.resolve = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_TICK:
            begin
                // hold on a due slot until the output register has room
                if (!sts.tick_hit || sts.out_free)
                begin
                    cmd.tick_step = 1'b1;
                    if (sts.idx_last)
                    begin
                        state_next = S_TDONE;
                    end
                end
            end
            S_TDONE:
            begin
                if (sts.out_free)
                begin
                    cmd.tick_done = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/ckt_dpath.sv -----
// Datapath: slot table, captured item, slot walk counter, idle compare and
// output register. Depends on ckt_pkg.
module ckt_dpath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ckt_pkg::ckt_cmd_t                cmd,
    output ckt_pkg::ckt_sts_t                sts,
    input  logic [ckt_pkg::OP_W-1:0]         in_op,
    input  logic [ckt_pkg::HANDLE_W-1:0]     in_handle,
    input  logic [ckt_pkg::TIME_W-1:0]       in_now_ms,
    input  logic [ckt_pkg::TIMEOUT_W-1:0]    timeout_ms,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [ckt_pkg::KIND_W-1:0]       out_kind,
    output logic [ckt_pkg::HANDLE_W-1:0]     out_handle,
    output logic [ckt_pkg::SLOT_W-1:0]       out_slot,
    output logic                             out_last
);

    // Slot table
    logic                             slot_valid_reg  [ckt_pkg::SLOTS];
    logic                             slot_pinged_reg [ckt_pkg::SLOTS];
    logic [ckt_pkg::HANDLE_W-1:0]     slot_handle_reg [ckt_pkg::SLOTS];
    logic [ckt_pkg::TIME_W-1:0]       slot_seen_reg   [ckt_pkg::SLOTS];

    // Captured item
    logic [ckt_pkg::OP_W-1:0]         op_reg;
    logic [ckt_pkg::HANDLE_W-1:0]     handle_reg;
    logic [ckt_pkg::TIME_W-1:0]       now_reg;

    // Walk and search results
    logic [ckt_pkg::IDX_W-1:0]        idx_reg;
    logic                             found_reg;
    logic [ckt_pkg::IDX_W-1:0]        found_idx_reg;
    logic                             free_reg;
    logic [ckt_pkg::IDX_W-1:0]        free_idx_reg;

    // Output register
    logic                             out_valid_reg;
    logic [ckt_pkg::KIND_W-1:0]       out_kind_reg;
    logic [ckt_pkg::HANDLE_W-1:0]     out_handle_reg;
    logic [ckt_pkg::SLOT_W-1:0]       out_slot_reg;
    logic                             out_last_reg;

    // Per-slot combinational view
    logic                             cur_valid;
    logic                             cur_pinged;
    logic [ckt_pkg::HANDLE_W-1:0]     cur_handle;
    logic [ckt_pkg::TIME_W:0]         idle_diff;
    logic [ckt_pkg::TIME_W-1:0]       idle_thr;
    logic                             tick_hit;
    logic                             emit;
    logic                             res_write;
    logic                             res_clear;
    logic [ckt_pkg::IDX_W-1:0]        res_idx;
    ckt_pkg::ckt_kind_t               res_kind;
    logic [ckt_pkg::SLOT_W-1:0]       res_slot;

    assign cur_valid  = slot_valid_reg[idx_reg];
    assign cur_pinged = slot_pinged_reg[idx_reg];
    assign cur_handle = slot_handle_reg[idx_reg];

    // Idle time against the ping or timeout threshold; time going back never expires
    assign idle_diff = {1'b0, now_reg} - {1'b0, slot_seen_reg[idx_reg]};
    assign idle_thr  = cur_pinged ? ckt_pkg::TIME_W'(timeout_ms)
                                  : ckt_pkg::TIME_W'(timeout_ms[ckt_pkg::TIMEOUT_W-1:1]);
    assign tick_hit  = cur_valid && !idle_diff[ckt_pkg::TIME_W]
                       && (idle_diff[ckt_pkg::TIME_W-1:0] > idle_thr);

    assign sts.op_tick  = (op_reg == ckt_pkg::OP_TICK);
    assign sts.idx_last = (idx_reg == ckt_pkg::IDX_W'(ckt_pkg::SLOTS - 1));
    assign sts.out_free = !out_valid_reg || out_ready;
    assign sts.tick_hit = tick_hit;

    // Decide the single result of connect, disconnect or activity
    always_comb
    begin
        res_write = 1'b0;
        res_clear = 1'b0;
        res_idx   = found_idx_reg;
        res_kind  = ckt_pkg::K_NOT_FOUND;
        res_slot  = '0;
        unique case (op_reg)
            ckt_pkg::OP_CONNECT:
            begin
                if (found_reg)
                begin
                    res_kind = ckt_pkg::K_DUPLICATE;
                    res_slot = ckt_pkg::SLOT_W'(found_idx_reg);
                end
                else if (free_reg)
                begin
                    res_write = 1'b1;
                    res_idx   = free_idx_reg;
                    res_kind  = ckt_pkg::K_CONNECTED;
                    res_slot  = ckt_pkg::SLOT_W'(free_idx_reg);
                end
                else
                begin
                    res_kind = ckt_pkg::K_FULL;
                end
            end
            ckt_pkg::OP_DISCONNECT:
            begin
                if (found_reg)
                begin
                    res_clear = 1'b1;
                    res_kind  = ckt_pkg::K_RELEASED;
                    res_slot  = ckt_pkg::SLOT_W'(found_idx_reg);
                end
            end
            ckt_pkg::OP_ACTIVITY:
            begin
                if (found_reg)
                begin
                    res_write = 1'b1;
                    res_kind  = ckt_pkg::K_REFRESHED;
                    res_slot  = ckt_pkg::SLOT_W'(found_idx_reg);
                end
            end
            default:
            begin
                res_kind = ckt_pkg::K_TICK_DONE;
            end
        endcase
    end

    assign emit = cmd.resolve || cmd.tick_done || (cmd.tick_step && tick_hit);

    // Walk counter, search flags and slot control bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            found_idx_reg <= '0;
            free_reg      <= 1'b0;
            free_idx_reg  <= '0;
            for (int i = 0; i < ckt_pkg::SLOTS; i++)
            begin
                slot_valid_reg[i]  <= 1'b0;
                slot_pinged_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
                free_reg  <= 1'b0;
            end
            if (cmd.search_step)
            begin
                if (!found_reg && cur_valid && (cur_handle == handle_reg))
                begin
                    found_reg     <= 1'b1;
                    found_idx_reg <= idx_reg;
                end
                if (!free_reg && !cur_valid)
                begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= idx_reg;
                end
            end
            if (cmd.search_step || cmd.tick_step)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.resolve && res_write)
            begin
                slot_valid_reg[res_idx]  <= 1'b1;
                slot_pinged_reg[res_idx] <= 1'b0;
            end
            if (cmd.resolve && res_clear)
            begin
                slot_valid_reg[res_idx]  <= 1'b0;
                slot_pinged_reg[res_idx] <= 1'b0;
            end
            // timeout frees a pinged slot, otherwise mark it pinged
            if (cmd.tick_step && tick_hit)
            begin
                if (cur_pinged)
                begin
                    slot_valid_reg[idx_reg]  <= 1'b0;
                    slot_pinged_reg[idx_reg] <= 1'b0;
                end
                else
                begin
                    slot_pinged_reg[idx_reg] <= 1'b1;
                end
            end
        end
    end

    // Captured item and slot payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= in_op;
            handle_reg <= in_handle;
            now_reg    <= in_now_ms;
        end
        if (cmd.resolve && res_write)
        begin
            slot_handle_reg[res_idx] <= handle_reg;
            slot_seen_reg[res_idx]   <= now_reg;
        end
    end

    // Output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (cmd.resolve)
        begin
            out_kind_reg   <= res_kind;
            out_handle_reg <= handle_reg;
            out_slot_reg   <= res_slot;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.tick_step && tick_hit)
        begin
            out_kind_reg   <= cur_pinged ? ckt_pkg::K_TIMED_OUT : ckt_pkg::K_PING;
            out_handle_reg <= cur_handle;
            out_slot_reg   <= ckt_pkg::SLOT_W'(idx_reg);
            out_last_reg   <= 1'b0;
        end
        else if (cmd.tick_done)
        begin
            out_kind_reg   <= ckt_pkg::K_TICK_DONE;
            out_handle_reg <= '0;
            out_slot_reg   <= '0;
            out_last_reg   <= 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_kind   = out_kind_reg;
    assign out_handle = out_handle_reg;
    assign out_slot   = out_slot_reg;
    assign out_last   = out_last_reg;

    // A result never overwrites one that is still waiting
    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!out_valid_reg || out_ready))
        else $error("result loaded while output register full");

    // A successful connect leaves its slot occupied
    a_connect_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.resolve && res_write) |=> slot_valid_reg[$past(res_idx)])
        else $error("connected slot not marked valid");

    // A timeout frees the slot it reports
    a_timeout_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.tick_step && tick_hit && cur_pinged) |=> !slot_valid_reg[$past(idx_reg)])
        else $error("timed out slot still valid");

    // A ping marks the slot it reports
    a_ping_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.tick_step && tick_hit && !cur_pinged) |=> slot_pinged_reg[$past(idx_reg)])
        else $error("pinged slot not marked");

endmodule

// ----- hw/rtl/connection_keepalive_table_unit.sv -----
// Top level of the connection keepalive table: controller, datapath, registers.
// Depends on ckt_pkg, ckt_in_if, ckt_out_if, ckt_regs, ckt_ctrl, ckt_dpath.
//
//   Channel   Dir  Handshake           Carries
//   events    in   valid/ready         op, handle, now_ms
//   results   out  valid/ready         kind, result_handle, slot, last
//   APB       in   psel/penable/pready timeout_ms at byte address 0
//
// Connect, disconnect and activity search one slot per cycle, then the table
// is updated and the result loaded.
// A tick is dispatched, then walks one slot per cycle unless a due slot waits
// on output backpressure, then loads the closing result.
// Both walks use the single slot-walk counter.
// Reset clears the table valid and ping bits and sets timeout_ms to 60000.
// A stalled result holds the walk only when another result is due.
module connection_keepalive_table_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    ckt_in_if.sink                            events,
    ckt_out_if.source                         results,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ckt_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ckt_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ckt_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    ckt_pkg::ckt_cmd_t                cmd;
    ckt_pkg::ckt_sts_t                sts;
    logic [ckt_pkg::TIMEOUT_W-1:0]    timeout_ms;
    logic                             in_ready;

    // Configuration registers
    ckt_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .timeout_ms (timeout_ms)
    );

    // Sequencer
    ckt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (events.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    assign events.ready = in_ready;

    // Table and output register
    ckt_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_op      (events.op),
        .in_handle  (events.handle),
        .in_now_ms  (events.now_ms),
        .timeout_ms (timeout_ms),
        .out_ready  (results.ready),
        .out_valid  (results.valid),
        .out_kind   (results.kind),
        .out_handle (results.result_handle),
        .out_slot   (results.slot),
        .out_last   (results.last)
    );

endmodule
